@@ rtl/core/tbms_pkg.sv @@
// tbms_pkg: shared types, constants and helpers for the tile brush mirror block
// depends on nothing; every other rtl/core file but tbms_ram refers to it by scoped names
package tbms_pkg;

  // brush and tile set sizing
  localparam int MAX_WIDTH     = 8;
  localparam int MAX_HEIGHT    = 8;
  localparam int TILESET_DEPTH = 2048;

  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CRD_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELL_SLOTS = 64;
  localparam int CELL_AW    = $clog2(CELL_SLOTS);
  localparam int SYM_AW     = (TILESET_DEPTH > 1) ? $clog2(TILESET_DEPTH) : 1;

  // fixed field widths
  localparam int DIM_W   = 4;
  localparam int TOTAL_W = 7;
  localparam int COUNT_W = 12;
  localparam int TILE_W  = 11;
  localparam int PAL_W   = 2;
  localparam int CFG_AW  = 2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_BRUSH_WIDTH   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BRUSH_HEIGHT  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TILESET_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_FLAGS = 2'd0,
    OP_LOAD_CELL  = 2'd1,
    OP_EMIT       = 2'd2,
    OP_CHECK      = 2'd3
  } op_t;

  // input request
  typedef struct packed {
    op_t                 operation;
    logic [CELL_AW-1:0]  cell_index;
    logic [TILE_W-1:0]   tile_number;
    logic [PAL_W-1:0]    palette_sel;
    logic                high_priority;
    logic                flip_h;
    logic                flip_v;
    logic                sym_x;
    logic                sym_y;
    logic                mirror_x;
    logic                mirror_y;
  } in_t;

  // result item
  typedef struct packed {
    logic [TILE_W-1:0] out_tile_number;
    logic [PAL_W-1:0]  out_palette_sel;
    logic              out_priority;
    logic              out_flip_h;
    logic              out_flip_v;
    logic              symmetric;
    logic              last;
  } out_t;

  // stored brush cell, same bit layout as the 16-bit brush word
  typedef struct packed {
    logic              flip_v;
    logic              flip_h;
    logic              prio;
    logic [PAL_W-1:0]  pal;
    logic [TILE_W-1:0] tile;
  } cell_t;

  // classified command between front and back
  typedef struct packed {
    op_t                op;
    logic [CELL_AW-1:0] cell_addr;
    cell_t              entry;
    logic [1:0]         sym;
    logic               mirror_x;
    logic               mirror_y;
  } cmd_t;

  // effective brush geometry
  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } geom_t;

  // clamp a size register to 1..maxv
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/tbms_ram.sv @@
// tbms_ram: generic single write port, single read port ram with registered read
// depends on nothing
module tbms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tbms_front.sv @@
// tbms_front: accepts input requests, drops out-of-range loads, builds commands
// depends on tbms_pkg
module tbms_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  tbms_pkg::in_t    in_data,
  input  tbms_pkg::geom_t  geom,
  input  logic             q_full,
  output logic             q_push,
  output tbms_pkg::cmd_t   q_cmd
);

  logic keep;

  // loads outside the brush or the tile set are dropped here
  always_comb begin
    case (in_data.operation)
      tbms_pkg::OP_LOAD_FLAGS: keep = (32'(in_data.tile_number) < tbms_pkg::TILESET_DEPTH);
      tbms_pkg::OP_LOAD_CELL:  keep = (tbms_pkg::TOTAL_W'(in_data.cell_index) < geom.total);
      default:                 keep = 1'b1;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

  // command packing
  always_comb begin
    q_cmd.op        = in_data.operation;
    q_cmd.cell_addr = in_data.cell_index;
    q_cmd.entry.flip_v = in_data.flip_v;
    q_cmd.entry.flip_h = in_data.flip_h;
    q_cmd.entry.prio   = in_data.high_priority;
    q_cmd.entry.pal    = in_data.palette_sel;
    q_cmd.entry.tile   = in_data.tile_number;
    q_cmd.sym       = {in_data.sym_y, in_data.sym_x};
    q_cmd.mirror_x  = in_data.mirror_x;
    q_cmd.mirror_y  = in_data.mirror_y;
  end

endmodule

@@ rtl/core/tbms_cmdq.sv @@
// tbms_cmdq: two-entry command queue between front and back
// depends on tbms_pkg
module tbms_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tbms_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tbms_pkg::cmd_t head
);

  tbms_pkg::cmd_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = q_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/tbms_back.sv @@
// tbms_back: executes loads, walks the brush for emit and check, holds result fifo
// depends on tbms_pkg and tbms_ram
module tbms_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tbms_pkg::geom_t geom,
  input  logic            q_valid,
  input  tbms_pkg::cmd_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output tbms_pkg::out_t  out_data
);

  localparam int OF_DEPTH = 4;
  localparam int OF_AW    = $clog2(OF_DEPTH);
  localparam int OFC_W    = OF_AW + 1;
  localparam int PROD_W   = 2 * tbms_pkg::DIM_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_DONE} state_t;

  state_t state_r, state_nxt;
  tbms_pkg::op_t op_r, op_nxt;
  logic mx_r, mx_nxt, my_r, my_nxt;
  logic [tbms_pkg::CRD_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [tbms_pkg::CELL_AW-1:0] k_r, k_nxt;
  logic p1_valid_r, p1_valid_nxt, p1_last_r, p1_last_nxt;
  logic p2_valid_r, p2_valid_nxt;
  tbms_pkg::cell_t p2_a_r, p2_b_r;
  logic equal_r, equal_nxt, xok_r, xok_nxt, yok_r, yok_nxt;
  tbms_pkg::out_t of_r [OF_DEPTH];
  logic [OF_AW-1:0] of_wp_r, of_wp_nxt, of_rp_r, of_rp_nxt;
  logic [OFC_W-1:0] of_cnt_r, of_cnt_nxt;
  tbms_pkg::out_t of_entry_nxt;

  logic [$bits(tbms_pkg::cell_t)-1:0] rd_a_raw, rd_b_raw;
  logic [1:0] sym_raw;
  tbms_pkg::cell_t cell_a, cell_b;
  logic brush_we, sym_we;
  logic issue, last_cell, credit_ok, row_end, of_push, of_pop;
  logic [tbms_pkg::TOTAL_W-1:0] total_m1;
  logic [tbms_pkg::DIM_W-1:0]   sx, sy;
  logic [PROD_W-1:0]            mirror_addr;
  logic data_match, in_set;

  // brush store, two copies written together so both walk reads happen in the same cycle
  tbms_ram #(.WIDTH($bits(tbms_pkg::cell_t)), .DEPTH(tbms_pkg::CELL_SLOTS)) u_brush_a (
    .clk   (clk),
    .we    (brush_we),
    .waddr (q_head.cell_addr),
    .wdata (q_head.entry),
    .raddr (k_r),
    .rdata (rd_a_raw)
  );

  tbms_ram #(.WIDTH($bits(tbms_pkg::cell_t)), .DEPTH(tbms_pkg::CELL_SLOTS)) u_brush_b (
    .clk   (clk),
    .we    (brush_we),
    .waddr (q_head.cell_addr),
    .wdata (q_head.entry),
    .raddr (mirror_addr[tbms_pkg::CELL_AW-1:0]),
    .rdata (rd_b_raw)
  );

  // tile symmetry flags, read with the tile of the current cell
  tbms_ram #(.WIDTH(2), .DEPTH(tbms_pkg::TILESET_DEPTH)) u_sym (
    .clk   (clk),
    .we    (sym_we),
    .waddr (tbms_pkg::SYM_AW'(q_head.entry.tile)),
    .wdata (q_head.sym),
    .raddr (tbms_pkg::SYM_AW'(cell_a.tile)),
    .rdata (sym_raw)
  );

  // stage 1 cells, mirrored cell with its flip bits toggled
  always_comb begin
    cell_a        = tbms_pkg::cell_t'(rd_a_raw);
    cell_b        = tbms_pkg::cell_t'(rd_b_raw);
    cell_b.flip_h = cell_b.flip_h ^ mx_r;
    cell_b.flip_v = cell_b.flip_v ^ my_r;
  end

  // source position of the mirrored cell
  always_comb begin
    sx = mx_r ? (geom.width - tbms_pkg::DIM_W'(1) - tbms_pkg::DIM_W'(x_r))
              : tbms_pkg::DIM_W'(x_r);
    sy = my_r ? (geom.height - tbms_pkg::DIM_W'(1) - tbms_pkg::DIM_W'(y_r))
              : tbms_pkg::DIM_W'(y_r);
    mirror_addr = PROD_W'(sy) * PROD_W'(geom.width) + PROD_W'(sx);
  end

  // walk control
  assign total_m1  = geom.total - tbms_pkg::TOTAL_W'(1);
  assign last_cell = (tbms_pkg::TOTAL_W'(k_r) == total_m1);
  assign row_end   = (tbms_pkg::DIM_W'(x_r) == geom.width - tbms_pkg::DIM_W'(1));
  assign credit_ok = (of_cnt_r + OFC_W'(p1_valid_r)) < OFC_W'(OF_DEPTH);
  assign issue     = (state_r == S_WALK) && ((op_r == tbms_pkg::OP_CHECK) || credit_ok);
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign brush_we  = q_pop && (q_head.op == tbms_pkg::OP_LOAD_CELL);
  assign sym_we    = q_pop && (q_head.op == tbms_pkg::OP_LOAD_FLAGS);

  // stage 2 compare of a cell with its mirror
  assign data_match = (p2_a_r.tile == p2_b_r.tile) && (p2_a_r.pal == p2_b_r.pal)
                      && (p2_a_r.prio == p2_b_r.prio);
  assign in_set     = (tbms_pkg::COUNT_W'(p2_a_r.tile) < geom.count);

  // result fifo
  assign out_valid = (of_cnt_r != '0);
  assign out_data  = of_r[of_rp_r];
  assign of_pop    = out_valid && out_ready;

  always_comb begin
    of_push      = 1'b0;
    of_entry_nxt = '0;
    if (p1_valid_r && (op_r == tbms_pkg::OP_EMIT)) begin
      of_push                      = 1'b1;
      of_entry_nxt.out_tile_number = cell_b.tile;
      of_entry_nxt.out_palette_sel = cell_b.pal;
      of_entry_nxt.out_priority    = cell_b.prio;
      of_entry_nxt.out_flip_h      = cell_b.flip_h;
      of_entry_nxt.out_flip_v      = cell_b.flip_v;
      of_entry_nxt.last            = p1_last_r;
    end else if ((state_r == S_DONE) && (of_cnt_r < OFC_W'(OF_DEPTH))) begin
      of_push                = 1'b1;
      of_entry_nxt.symmetric = (mx_r || my_r) && equal_r && (!mx_r || xok_r)
                               && (!my_r || yok_r);
      of_entry_nxt.last      = 1'b1;
    end
    of_wp_nxt  = of_push ? of_wp_r + OF_AW'(1) : of_wp_r;
    of_rp_nxt  = of_pop ? of_rp_r + OF_AW'(1) : of_rp_r;
    of_cnt_nxt = of_cnt_r + OFC_W'(of_push) - OFC_W'(of_pop);
  end

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    mx_nxt       = mx_r;
    my_nxt       = my_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    k_nxt        = k_r;
    equal_nxt    = equal_r;
    xok_nxt      = xok_r;
    yok_nxt      = yok_r;
    p1_valid_nxt = issue;
    p1_last_nxt  = last_cell;
    p2_valid_nxt = p1_valid_r && (op_r == tbms_pkg::OP_CHECK);

    // running symmetry verdict
    if (p2_valid_r) begin
      if (!data_match) begin
        equal_nxt = 1'b0;
      end else if (in_set) begin
        if (mx_r && !sym_raw[0] && (p2_a_r.flip_h != p2_b_r.flip_h)) begin
          xok_nxt = 1'b0;
        end
        if (my_r && !sym_raw[1] && (p2_a_r.flip_v != p2_b_r.flip_v)) begin
          yok_nxt = 1'b0;
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (q_pop && ((q_head.op == tbms_pkg::OP_EMIT)
                      || (q_head.op == tbms_pkg::OP_CHECK))) begin
          state_nxt = S_WALK;
          op_nxt    = q_head.op;
          mx_nxt    = q_head.mirror_x;
          my_nxt    = q_head.mirror_y;
          x_nxt     = '0;
          y_nxt     = '0;
          k_nxt     = '0;
          equal_nxt = 1'b1;
          xok_nxt   = 1'b1;
          yok_nxt   = 1'b1;
        end
      end
      S_WALK: begin
        if (issue) begin
          k_nxt = k_r + tbms_pkg::CELL_AW'(1);
          if (row_end) begin
            x_nxt = '0;
            y_nxt = y_r + tbms_pkg::CRD_W'(1);
          end else begin
            x_nxt = x_r + tbms_pkg::CRD_W'(1);
          end
          if (last_cell) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!p1_valid_r && !p2_valid_r) begin
          state_nxt = (op_r == tbms_pkg::OP_CHECK) ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (of_push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      op_r       <= tbms_pkg::OP_LOAD_FLAGS;
      mx_r       <= 1'b0;
      my_r       <= 1'b0;
      x_r        <= '0;
      y_r        <= '0;
      k_r        <= '0;
      equal_r    <= 1'b1;
      xok_r      <= 1'b1;
      yok_r      <= 1'b1;
      p1_valid_r <= 1'b0;
      p1_last_r  <= 1'b0;
      p2_valid_r <= 1'b0;
      of_wp_r    <= '0;
      of_rp_r    <= '0;
      of_cnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      mx_r       <= mx_nxt;
      my_r       <= my_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      k_r        <= k_nxt;
      equal_r    <= equal_nxt;
      xok_r      <= xok_nxt;
      yok_r      <= yok_nxt;
      p1_valid_r <= p1_valid_nxt;
      p1_last_r  <= p1_last_nxt;
      p2_valid_r <= p2_valid_nxt;
      of_wp_r    <= of_wp_nxt;
      of_rp_r    <= of_rp_nxt;
      of_cnt_r   <= of_cnt_nxt;
    end
    p2_a_r <= cell_a;
    p2_b_r <= cell_b;
    if (of_push) begin
      of_r[of_wp_r] <= of_entry_nxt;
    end
  end

endmodule

@@ rtl/core/tile_brush_mirror_symmetry.sv @@
// tile_brush_mirror_symmetry: top level, config registers, front, queue and back
// depends on tbms_pkg, tbms_front, tbms_cmdq, tbms_back (and tbms_ram below it)
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (tbms_pkg::in_t)
//  out     | output    | out_valid / out_ready | out_data (tbms_pkg::out_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// the back end executes a load as it pops it from the queue; emit walks the brush one
// brush cell per cycle while the result fifo has room, reading from the two brush ram copies
// check does the same cell walk without pausing for the fifo and gives one result
// a two-entry command queue lets the front keep accepting while the back walks
// output stalls are absorbed by a four-entry result fifo; an emit walk pauses on it
// synchronous active-low reset; no ram clearing pass, stores are undefined
module tile_brush_mirror_symmetry (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tbms_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tbms_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbms_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [tbms_pkg::COUNT_W-1:0]  cfg_data
);

  logic [tbms_pkg::DIM_W-1:0]   width_r, width_nxt;
  logic [tbms_pkg::DIM_W-1:0]   height_r, height_nxt;
  logic [tbms_pkg::COUNT_W-1:0] count_r, count_nxt;
  tbms_pkg::geom_t geom;
  tbms_pkg::cmd_t  push_cmd, head_cmd;
  logic q_push, q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // register writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    count_nxt  = count_r;
    if (cfg_valid) begin
      case (cfg_index)
        tbms_pkg::CFG_BRUSH_WIDTH:   width_nxt  = cfg_data[tbms_pkg::DIM_W-1:0];
        tbms_pkg::CFG_BRUSH_HEIGHT:  height_nxt = cfg_data[tbms_pkg::DIM_W-1:0];
        tbms_pkg::CFG_TILESET_COUNT: count_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tbms_pkg::DIM_W'(1);
      height_r <= tbms_pkg::DIM_W'(1);
      count_r  <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      count_r  <= count_nxt;
    end
  end

  // effective geometry with clamped sizes and saturated tile count
  always_comb begin
    geom.width  = tbms_pkg::eff_dim(width_r, tbms_pkg::DIM_W'(tbms_pkg::MAX_WIDTH));
    geom.height = tbms_pkg::eff_dim(height_r, tbms_pkg::DIM_W'(tbms_pkg::MAX_HEIGHT));
    geom.total  = tbms_pkg::TOTAL_W'(geom.width) * tbms_pkg::TOTAL_W'(geom.height);
    geom.count  = (32'(count_r) > tbms_pkg::TILESET_DEPTH)
                  ? tbms_pkg::COUNT_W'(tbms_pkg::TILESET_DEPTH) : count_r;
  end

  tbms_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .geom     (geom),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  tbms_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  tbms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .q_valid   (q_valid),
    .q_head    (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/tile_brush_mirror_symmetry_test.sv @@
// tile_brush_mirror_symmetry_test: self-checking bench for the brush mirror and symmetry block
// depends on tbms_pkg and tile_brush_mirror_symmetry; predicts every result from its own model
module tile_brush_mirror_symmetry_test;
  import tbms_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 24;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 34;
  localparam int POOL_SIZE      = 8;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_t                in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_AW-1:0]  cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data  = '0;

  tile_brush_mirror_symmetry u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // predicted block state and register copies
  cell_t              brush_img [CELL_SLOTS];
  logic [1:0]         tile_sym [TILESET_DEPTH];
  logic [DIM_W-1:0]   reg_width  = DIM_W'(1);
  logic [DIM_W-1:0]   reg_height = DIM_W'(1);
  logic [COUNT_W-1:0] reg_count  = '0;
  out_t               mirror_results [$];
  in_t                pending_requests [$];

  // request generator's view of what has been written
  bit                 gen_cell_set [CELL_SLOTS];
  logic [TILE_W-1:0]  gen_tile [CELL_SLOTS];
  bit                 gen_flag_set [TILESET_DEPTH];
  logic [TILE_W-1:0]  tile_pool [POOL_SIZE];

  bit idle_on          = 1'b1;
  int send_gap         = 0;
  int stall_left       = 0;
  int hold_ask         = 0;
  int hold_seen        = 0;
  int quiet_cycles     = 0;
  int error_count      = 0;
  int queued_items     = 0;
  int accepted_requests = 0;
  int cells_streamed   = 0;
  int checks_run       = 0;
  int checks_symmetric = 0;
  int settings_used    = 0;

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int brush_cols();
    return clamp_dim(reg_width, MAX_WIDTH);
  endfunction

  function automatic int brush_rows();
    return clamp_dim(reg_height, MAX_HEIGHT);
  endfunction

  function automatic int tile_limit();
    return (int'(reg_count) > TILESET_DEPTH) ? TILESET_DEPTH : int'(reg_count);
  endfunction

  // cell that lands at (x, y) after mirroring, flips toggled on the mirrored axes
  function automatic cell_t mirrored_at(input int x, input int y, input int w, input int h,
                                        input logic mx, input logic my);
    cell_t c;
    int sx;
    int sy;
    sx = mx ? (w - 1 - x) : x;
    sy = my ? (h - 1 - y) : y;
    c = brush_img[(sy * w + sx) % CELL_SLOTS];
    c.flip_h = c.flip_h ^ mx;
    c.flip_v = c.flip_v ^ my;
    return c;
  endfunction

  // update the state copy and queue the results one accepted request causes
  task automatic predict_request(input in_t r);
    int    w;
    int    h;
    int    total;
    int    limit;
    cell_t a;
    cell_t b;
    out_t  res;
    logic  equal;
    logic  x_ok;
    logic  y_ok;
    w = brush_cols();
    h = brush_rows();
    total = w * h;
    limit = tile_limit();
    case (r.operation)
      OP_LOAD_FLAGS: begin
        tile_sym[r.tile_number] = {r.sym_y, r.sym_x};
      end
      OP_LOAD_CELL: begin
        if (int'(r.cell_index) < total) begin
          a.tile   = r.tile_number;
          a.pal    = r.palette_sel;
          a.prio   = r.high_priority;
          a.flip_h = r.flip_h;
          a.flip_v = r.flip_v;
          brush_img[r.cell_index] = a;
        end
      end
      OP_EMIT: begin
        for (int k = 0; k < total; k++) begin
          a = mirrored_at(k % w, k / w, w, h, r.mirror_x, r.mirror_y);
          res = '0;
          res.out_tile_number = a.tile;
          res.out_palette_sel = a.pal;
          res.out_priority    = a.prio;
          res.out_flip_h      = a.flip_h;
          res.out_flip_v      = a.flip_v;
          res.last            = (k == total - 1);
          mirror_results.push_back(res);
          cells_streamed++;
        end
      end
      OP_CHECK: begin
        equal = 1'b1;
        x_ok  = 1'b1;
        y_ok  = 1'b1;
        for (int k = 0; k < total; k++) begin
          a = brush_img[k];
          b = mirrored_at(k % w, k / w, w, h, r.mirror_x, r.mirror_y);
          if ({a.prio, a.pal, a.tile} != {b.prio, b.pal, b.tile}) begin
            equal = 1'b0;
          end else if (int'(a.tile) < limit) begin
            // flip mismatch only matters for a tile that is not symmetric itself
            if (r.mirror_x && !tile_sym[a.tile][0] && a.flip_h != b.flip_h) x_ok = 1'b0;
            if (r.mirror_y && !tile_sym[a.tile][1] && a.flip_v != b.flip_v) y_ok = 1'b0;
          end
        end
        res = '0;
        res.symmetric = (r.mirror_x || r.mirror_y) && equal &&
                        (!r.mirror_x || x_ok) && (!r.mirror_y || y_ok);
        res.last = 1'b1;
        mirror_results.push_back(res);
        checks_run++;
        if (res.symmetric) checks_symmetric++;
      end
      default: begin
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        accepted_requests++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
          send_gap <= idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [TILE_W-1:0] want,
                               input logic [TILE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (mirror_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      error_count++;
    end else begin
      want = mirror_results.pop_front();
      compare_field("tile", want.out_tile_number, got.out_tile_number);
      compare_field("palette", TILE_W'(want.out_palette_sel), TILE_W'(got.out_palette_sel));
      compare_field("priority", TILE_W'(want.out_priority), TILE_W'(got.out_priority));
      compare_field("flip_h", TILE_W'(want.out_flip_h), TILE_W'(got.out_flip_h));
      compare_field("flip_v", TILE_W'(want.out_flip_v), TILE_W'(got.out_flip_v));
      compare_field("symmetric", TILE_W'(want.symmetric), TILE_W'(got.symmetric));
      compare_field("last", TILE_W'(want.last), TILE_W'(got.last));
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_seen  <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_seen != hold_ask) begin
        hold_seen  <= hold_ask;
        stall_left <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic [CFG_AW-1:0] idx, input logic [COUNT_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BRUSH_WIDTH:   reg_width  = val[DIM_W-1:0];
      CFG_BRUSH_HEIGHT:  reg_height = val[DIM_W-1:0];
      CFG_TILESET_COUNT: reg_count  = val;
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained(input int settle);
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || mirror_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  function automatic in_t random_request(input op_t op);
    in_t r;
    r = $bits(in_t)'($urandom);
    r.operation = op;
    return r;
  endfunction

  function automatic logic [TILE_W-1:0] pick_tile();
    if ($urandom_range(0, 3) != 0) return tile_pool[$urandom_range(0, POOL_SIZE - 1)];
    return TILE_W'($urandom);
  endfunction

  function automatic void queue_item(input in_t r);
    if (r.operation == OP_LOAD_CELL && int'(r.cell_index) < brush_cols() * brush_rows()) begin
      gen_cell_set[r.cell_index] = 1'b1;
      gen_tile[r.cell_index]     = r.tile_number;
    end
    if (r.operation == OP_LOAD_FLAGS) gen_flag_set[r.tile_number] = 1'b1;
    pending_requests.push_back(r);
    queued_items++;
  endfunction

  // write any brush cell or tile flag that the next walk would read unwritten
  function automatic void cover_reads();
    in_t r;
    int  total;
    total = brush_cols() * brush_rows();
    for (int k = 0; k < total; k++) begin
      if (!gen_cell_set[k]) begin
        r = random_request(OP_LOAD_CELL);
        r.cell_index  = CELL_AW'(k);
        r.tile_number = pick_tile();
        queue_item(r);
      end
    end
    for (int k = 0; k < total; k++) begin
      if (int'(gen_tile[k]) < tile_limit() && !gen_flag_set[gen_tile[k]]) begin
        r = random_request(OP_LOAD_FLAGS);
        r.tile_number = gen_tile[k];
        queue_item(r);
      end
    end
  endfunction

  function automatic void queue_walk(input in_t r);
    cover_reads();
    queue_item(r);
  endfunction

  function automatic void queue_mirror(input op_t op, input logic mx, input logic my);
    in_t r;
    r = random_request(op);
    r.mirror_x = mx;
    r.mirror_y = my;
    queue_walk(r);
  endfunction

  // brush that matches its own mirror image, with a few flips and palettes disturbed
  function automatic void queue_sym_brush(input logic mx, input logic my);
    in_t a;
    in_t b;
    int  w;
    int  h;
    int  q;
    w = brush_cols();
    h = brush_rows();
    for (int k = 0; k < w * h; k++) begin
      q = (my ? (h - 1 - k / w) : k / w) * w + (mx ? (w - 1 - k % w) : k % w);
      if (q < k) continue;
      a = random_request(OP_LOAD_CELL);
      a.cell_index  = CELL_AW'(k);
      a.tile_number = pick_tile();
      queue_item(a);
      if (q != k) begin
        b = a;
        b.cell_index = CELL_AW'(q);
        b.flip_h = a.flip_h ^ mx;
        b.flip_v = a.flip_v ^ my;
        if ($urandom_range(0, 9) == 0) begin
          b.flip_h = 1'($urandom);
          b.flip_v = 1'($urandom);
        end
        if ($urandom_range(0, 19) == 0) b.palette_sel = PAL_W'($urandom);
        queue_item(b);
      end
    end
  endfunction

  function automatic void random_phase(input int budget);
    in_t  r;
    int   start;
    int   pick;
    int   limit;
    logic mx;
    logic my;
    start = queued_items;
    limit = tile_limit();
    // tile pool around the tile set boundary, flags loaded up front
    tile_pool[0] = '0;
    tile_pool[1] = '1;
    tile_pool[2] = (limit > 0) ? TILE_W'(limit - 1) : TILE_W'($urandom);
    tile_pool[3] = TILE_W'(limit);
    for (int i = 4; i < POOL_SIZE; i++) tile_pool[i] = TILE_W'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      r = random_request(OP_LOAD_FLAGS);
      r.tile_number = tile_pool[i];
      queue_item(r);
    end
    while (queued_items - start < budget) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 40) begin
        mx = 1'($urandom);
        my = 1'($urandom);
        if (!mx && !my && $urandom_range(0, 3) != 0) mx = 1'b1;
        queue_sym_brush(mx, my);
        queue_mirror(OP_CHECK, mx, my);
        if ($urandom_range(0, 1) == 0) queue_mirror(OP_EMIT, mx, my);
      end else if (pick < 65) begin
        r = random_request(OP_LOAD_CELL);
        if ($urandom_range(0, 1) == 0) r.tile_number = pick_tile();
        queue_item(r);
      end else if (pick < 75) begin
        r = random_request(OP_LOAD_FLAGS);
        r.tile_number = tile_pool[$urandom_range(0, POOL_SIZE - 1)];
        queue_item(r);
      end else if (pick < 90) begin
        queue_mirror(($urandom_range(0, 1) == 0) ? OP_EMIT : OP_CHECK,
                     1'($urandom), 1'($urandom));
      end else begin
        r = random_request(op_t'(2'($urandom)));
        if (r.operation == OP_EMIT || r.operation == OP_CHECK) queue_walk(r);
        else queue_item(r);
      end
    end
  endfunction

  task automatic run_phase(input int w, input int h, input int n, input bit calm,
                           input bit squeeze);
    wait_drained(SETTLE_CYCLES);
    write_register(CFG_BRUSH_WIDTH, {8'($urandom), 4'(w)});
    write_register(CFG_BRUSH_HEIGHT, {8'($urandom), 4'(h)});
    write_register(CFG_TILESET_COUNT, COUNT_W'(n));
    @(negedge clk);
    settings_used++;
    idle_on = !calm;
    random_phase(PHASE_ITEMS);
    if (squeeze) begin
      // receiver holds off while emits pile up behind it
      hold_ask++;
      repeat (6) queue_mirror(OP_EMIT, 1'($urandom), 1'($urandom));
      wait_drained(0);
      random_phase(PHASE_ITEMS / 2);
    end
  endtask

  function automatic void directed_flags(input logic [TILE_W-1:0] tile, input logic sx,
                                         input logic sy);
    in_t r;
    r = random_request(OP_LOAD_FLAGS);
    r.tile_number = tile;
    r.sym_x = sx;
    r.sym_y = sy;
    queue_item(r);
  endfunction

  function automatic void directed_cell(input int idx, input logic [TILE_W-1:0] tile,
                                        input logic [PAL_W-1:0] pal, input logic prio,
                                        input logic fh, input logic fv);
    in_t r;
    r = random_request(OP_LOAD_CELL);
    r.cell_index    = CELL_AW'(idx);
    r.tile_number   = tile;
    r.palette_sel   = pal;
    r.high_priority = prio;
    r.flip_h        = fh;
    r.flip_v        = fv;
    queue_item(r);
  endfunction

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 3x2 brush, tile set of 6 so the top tile lies beyond it
    write_register(CFG_BRUSH_WIDTH, COUNT_W'(3));
    write_register(CFG_BRUSH_HEIGHT, COUNT_W'(2));
    write_register(CFG_TILESET_COUNT, COUNT_W'(6));
    @(negedge clk);
    settings_used++;
    directed_flags(TILE_W'(0), 1'b0, 1'b0);
    directed_flags('1, 1'b1, 1'b1);
    directed_flags(TILE_W'(5), 1'b1, 1'b0);
    directed_flags(TILE_W'(4), 1'b0, 1'b1);
    directed_cell(0, TILE_W'(0), 2'd0, 1'b0, 1'b0, 1'b0);
    directed_cell(1, TILE_W'(5), 2'd1, 1'b1, 1'b1, 1'b0);
    directed_cell(2, TILE_W'(0), 2'd0, 1'b0, 1'b1, 1'b0);
    directed_cell(3, '1, '1, 1'b1, 1'b1, 1'b1);
    directed_cell(4, TILE_W'(4), 2'd2, 1'b0, 1'b0, 1'b1);
    directed_cell(5, '1, '1, 1'b1, 1'b0, 1'b0);
    // cell loads past the brush are dropped
    directed_cell(63, TILE_W'(1), 2'd1, 1'b0, 1'b0, 1'b0);
    directed_cell(6, TILE_W'(3), 2'd2, 1'b1, 1'b1, 1'b1);
    for (int m = 0; m < 4; m++) queue_mirror(OP_EMIT, m[0], m[1]);
    for (int m = 0; m < 4; m++) queue_mirror(OP_CHECK, m[0], m[1]);
    wait_drained(SETTLE_CYCLES);

    // random phases over register settings, out-of-range sizes and counts included
    run_phase(1, 1, 0, 1'b1, 1'b0);
    run_phase(8, 8, 2048, 1'b0, 1'b0);
    run_phase(0, 0, 4095, 1'b0, 1'b0);
    run_phase(15, 3, 100, 1'b0, 1'b0);
    run_phase(4, 8, 5, 1'b0, 1'b1);
    run_phase(8, 1, 2047, 1'b0, 1'b0);
    run_phase(3, 5, 1, 1'b1, 1'b0);
    run_phase(5, 7, 1500, 1'b0, 1'b0);
    run_phase(2, 8, 3000, 1'b0, 1'b0);

    wait_drained(TAIL_CYCLES);
    $display("covered %0d requests over %0d register settings, %0d mirrored cells streamed",
             accepted_requests, settings_used, cells_streamed);
    $display("ran %0d symmetry checks, %0d found symmetric", checks_run, checks_symmetric);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
